@@ src/mssp_pkg.sv @@
package mssp_pkg;

  // Default sizes of the block.
  localparam int NUM_STACKS_DEF   = 4;
  localparam int POOL_ENTRIES_DEF = 64;

  // Fixed field widths of the two channels.
  localparam int OPCODE_W = 1;
  localparam int STACK_W  = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

@@ src/mssp_pool.sv @@
module mssp_pool #(
  parameter int POOL_ENTRIES = mssp_pkg::POOL_ENTRIES_DEF,
  parameter int IDX_W        = $clog2(POOL_ENTRIES + 1),
  parameter int ADDR_W       = $clog2(POOL_ENTRIES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  input  logic                         wr_en,
  input  logic                         wr_value_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [mssp_pkg::VALUE_W-1:0] wr_value,
  input  logic [IDX_W-1:0]             wr_link,
  output logic [mssp_pkg::VALUE_W-1:0] rd_value,
  output logic [IDX_W-1:0]             rd_link
);

  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_ENTRIES);

  logic [mssp_pkg::VALUE_W-1:0] value_mem [POOL_ENTRIES];
  logic [IDX_W-1:0]             link_mem  [POOL_ENTRIES];

  // Entries at or above the fill count have never been taken from the free
  // list, so their link is still the reset chain to the next entry.
  logic [IDX_W-1:0] fill_r;
  logic [IDX_W-1:0] fill_nxt;
  logic [IDX_W-1:0] rd_addr_r;
  logic             rd_fresh_r;
  logic [IDX_W-1:0] link_q_r;
  logic [IDX_W-1:0] chain_link;

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (IDX_W'(wr_addr) == fill_r)) begin
      fill_nxt = fill_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_link;
      if (wr_value_en) begin
        value_mem[wr_addr] <= wr_value;
      end
    end
    if (rd_en) begin
      link_q_r   <= link_mem[rd_addr];
      rd_value   <= value_mem[rd_addr];
      rd_addr_r  <= IDX_W'(rd_addr);
      rd_fresh_r <= (IDX_W'(rd_addr) >= fill_r);
    end
  end

  always_comb begin
    chain_link = rd_addr_r + IDX_W'(1);
    if (chain_link >= NIL) begin
      chain_link = NIL;
    end
    rd_link = rd_fresh_r ? chain_link : link_q_r;
  end

endmodule

@@ src/multi_stack_shared_pool_top.sv @@
// Several stacks that share one pool of entries, kept as linked lists with a
// common free list.
//
// Input channel (in_valid/in_ready): one word carries an opcode (push or
// pop), a zero-based stack number and, for a push, the value to store.
// Result channel (out_valid/out_ready): exactly one word per input word,
// with a status (ok, overflow on a full pool or bad stack, underflow on an
// empty or bad stack) and the popped value, zero unless a pop succeeded.
//
// Each word is handled in an accept step and an update step: the accepting
// edge reads the entry's link and value from the pool memories, and the
// update edge updates the lists and loads the output register. No new word
// is taken until the previous one has finished its update. The synchronous
// read of the pool memories sets this split. in_ready is low during the
// update cycle. If the receiver stalls with a result still held, the update
// cycle waits until the output register frees.
//
// Reset (rst_n, synchronous, active low) empties all stacks, puts every
// entry on the free list and marks the output register empty. No clearing
// pass is needed: a fill count marks the entries never yet used.
module multi_stack_shared_pool_top #(
  parameter int NUM_STACKS   = mssp_pkg::NUM_STACKS_DEF,
  parameter int POOL_ENTRIES = mssp_pkg::POOL_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mssp_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [mssp_pkg::STACK_W-1:0]  in_stack_number,
  input  logic signed [mssp_pkg::VALUE_W-1:0] in_push_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mssp_pkg::STATUS_W-1:0] out_status,
  output logic signed [mssp_pkg::VALUE_W-1:0] out_popped_value
);

  localparam int IDX_W  = $clog2(POOL_ENTRIES + 1);
  localparam int ADDR_W = $clog2(POOL_ENTRIES);
  localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_ENTRIES);

  // Sequencer states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // The item being worked on.
  logic [mssp_pkg::OPCODE_W-1:0] op_r;
  logic [STK_W-1:0]              sn_r;
  logic                          sn_ok_r;
  logic [mssp_pkg::VALUE_W-1:0]  val_r;
  logic [IDX_W-1:0]              addr_r;

  // List heads.
  logic [IDX_W-1:0] tops_r [NUM_STACKS];
  logic [IDX_W-1:0] free_head_r;

  logic                          out_valid_r;
  logic [mssp_pkg::STATUS_W-1:0] out_status_r;
  logic [mssp_pkg::VALUE_W-1:0]  out_popped_r;

  logic                         accept;
  logic [STK_W-1:0]             in_sn;
  logic                         in_sn_ok;
  logic [IDX_W-1:0]             in_top;
  logic [IDX_W-1:0]             rd_sel;
  logic                         out_free;
  logic                         finish;
  logic                         fail;
  logic                         commit;
  logic [IDX_W-1:0]             next_link;
  logic [mssp_pkg::VALUE_W-1:0] pool_value;
  logic [IDX_W-1:0]             pool_link;
  logic [IDX_W-1:0]             wr_link;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Select the entry to read: a push uses the free head, a pop the top.
  always_comb begin
    in_sn    = STK_W'(in_stack_number);
    in_sn_ok = (32'(in_stack_number) < 32'(NUM_STACKS));
    in_top   = in_sn_ok ? tops_r[in_sn] : NIL;
    rd_sel   = (in_opcode == mssp_pkg::OP_POP) ? in_top : free_head_r;
  end

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    finish    = (state_r == S_EXEC) && out_free;
    fail      = !sn_ok_r || (addr_r >= NIL);
    commit    = finish && !fail;
    next_link = (pool_link < NIL) ? pool_link : NIL;
    wr_link   = (op_r == mssp_pkg::OP_PUSH) ? tops_r[sn_r] : free_head_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  mssp_pool #(
    .POOL_ENTRIES(POOL_ENTRIES),
    .IDX_W       (IDX_W),
    .ADDR_W      (ADDR_W)
  ) u_pool (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (rd_sel[ADDR_W-1:0]),
    .wr_en      (commit),
    .wr_value_en(op_r == mssp_pkg::OP_PUSH),
    .wr_addr    (addr_r[ADDR_W-1:0]),
    .wr_value   (val_r),
    .wr_link    (wr_link),
    .rd_value   (pool_value),
    .rd_link    (pool_link)
  );

  // Item and result registers: payload only.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      sn_r    <= in_sn;
      sn_ok_r <= in_sn_ok;
      val_r   <= in_push_value;
      addr_r  <= rd_sel;
    end
    if (finish) begin
      if (fail) begin
        out_status_r <= (op_r == mssp_pkg::OP_PUSH) ? mssp_pkg::ST_OVERFLOW
                                                    : mssp_pkg::ST_UNDERFLOW;
        out_popped_r <= '0;
      end else begin
        out_status_r <= mssp_pkg::ST_OK;
        out_popped_r <= (op_r == mssp_pkg::OP_POP) ? pool_value : '0;
      end
    end
  end

  // Control state, output valid and list heads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_head_r <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= NIL;
      end
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        if (op_r == mssp_pkg::OP_PUSH) begin
          // The free head becomes the new top; its old link is the new head.
          free_head_r  <= next_link;
          tops_r[sn_r] <= addr_r;
        end else begin
          // The old top returns to the front of the free list.
          tops_r[sn_r] <= next_link;
          free_head_r  <= addr_r;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;

`ifndef SYNTH
  // An accepted word blocks the input for the update cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken during update cycle");

  // Only a successful pop carries a nonzero popped value.
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mssp_pkg::ST_OK) |-> (out_popped_value == '0))
    else $error("popped value nonzero on failed operation");

  // A successful push always moves the free head.
  a_push_moves_free: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && op_r == mssp_pkg::OP_PUSH) |=> (free_head_r != $past(free_head_r)))
    else $error("free head did not move on push");

  // A finished item never overwrites a result still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
                                   && $stable(out_popped_value)))
    else $error("held result changed");
`endif

endmodule
